FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/gsa_pkg.sv
// ----------------------------------------------------------------------------
// gsa_pkg
// types and constants of the generational slot allocator
// ----------------------------------------------------------------------------
`default_nettype none

package gsa_pkg;

    localparam int IDX_W     = 12;
    localparam int GEN_W     = 32;
    localparam int CFG_W     = 13;
    localparam int WORD_BITS = 64;

    localparam logic [CFG_W-1:0]     SLOTS_RESET = 13'd4096;
    localparam logic [WORD_BITS-1:0] TOP_BIT     = 64'h8000000000000000;

    // opcodes
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_STALE = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_FIND,
        S_EXEC
    } gsa_state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic read;
        logic find;
        logic exec;
    } gsa_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_alloc;
    } gsa_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/generational_slot_allocator.sv
// ----------------------------------------------------------------------------
// generational_slot_allocator
// slot pool with occupancy bitmap and per-slot generation counts
//
// channel   direction  signals                                    handshake
// request   in         opcode slot_index generation               start & !busy
// result    out        status granted_index granted_generation    done, 1 cycle
//                      alive
// config    in         cfg_wr_data                                cfg_wr_en
//
// allocate steps from accept to done through occupancy word read, free bit
// search plus generation read, then execute; the free-word summary picks the
// word at accept. delete, check and the unused opcode skip the free bit search.
// after reset a clearing pass over all SLOTS slots (4096 by default) zeroes both
// memories with busy high; config writes are taken at any time.
// a new request is taken in the cycle done is shown; results cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module generational_slot_allocator
#(
    parameter int SLOTS    = 4096,
    parameter int GEN_BITS = 32
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    opcode,
    input  wire logic [gsa_pkg::IDX_W-1:0]     slot_index,
    input  wire logic [gsa_pkg::GEN_W-1:0]     generation,
    input  wire logic                          cfg_wr_en,
    input  wire logic [gsa_pkg::CFG_W-1:0]     cfg_wr_data,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [gsa_pkg::IDX_W-1:0]          granted_index,
    output logic [gsa_pkg::GEN_W-1:0]          granted_generation,
    output logic                               alive
);
    import gsa_pkg::*;

    gsa_cmd_t  cmd;
    gsa_stat_t stat;

    gsa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    gsa_datapath
    #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS)
    )
    u_datapath
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .opcode             (opcode),
        .slot_index         (slot_index),
        .generation         (generation),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .done               (done),
        .status             (status),
        .granted_index      (granted_index),
        .granted_generation (granted_generation),
        .alive              (alive)
    );

    // assertions
    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "done held over two cycles")
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "no busy after accept")
    `ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy, "done shown while busy")
    `ASSERT_IMP(a_alive_ok, clk, rst_n, done && alive, status == ST_OK, "alive without ok")

endmodule

`default_nettype wire

FILE: rtl/core/gsa_ctrl.sv
// ----------------------------------------------------------------------------
// gsa_ctrl
// sequencer: clearing pass, request capture, memory reads, execute
// ----------------------------------------------------------------------------
`default_nettype none

module gsa_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  gsa_pkg::gsa_stat_t     stat,
    output gsa_pkg::gsa_cmd_t      cmd,
    output logic                   busy
);
    import gsa_pkg::*;

    gsa_state_t state_reg;
    gsa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = stat.is_alloc ? S_FIND : S_EXEC;
            end
            S_FIND:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            S_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
            end
            S_READ:
            begin
                cmd.read = 1'b1;
            end
            S_FIND:
            begin
                cmd.find = 1'b1;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/gsa_datapath.sv
// ----------------------------------------------------------------------------
// gsa_datapath
// occupancy and generation memories, free-word summary, result registers
// ----------------------------------------------------------------------------
`default_nettype none

module gsa_datapath
#(
    parameter int SLOTS    = 4096,
    parameter int GEN_BITS = 32
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  gsa_pkg::gsa_cmd_t                  cmd,
    output gsa_pkg::gsa_stat_t                 stat,
    input  wire logic [1:0]                    opcode,
    input  wire logic [gsa_pkg::IDX_W-1:0]     slot_index,
    input  wire logic [gsa_pkg::GEN_W-1:0]     generation,
    input  wire logic                          cfg_wr_en,
    input  wire logic [gsa_pkg::CFG_W-1:0]     cfg_wr_data,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [gsa_pkg::IDX_W-1:0]          granted_index,
    output logic [gsa_pkg::GEN_W-1:0]          granted_generation,
    output logic                               alive
);
    import gsa_pkg::*;

    localparam int WORDS     = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WB        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SW        = WB + 6;
    localparam int OCC_DEPTH = 1 << WB;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

    logic [WORD_BITS-1:0] occ_mem [OCC_DEPTH];
    logic [GEN_BITS-1:0]  gen_mem [SLOTS];

    logic [CFG_W-1:0]     slots_in_use_reg;
    logic [SW-1:0]        clr_cnt_reg;
    logic [WORDS-1:0]     summary_reg;
    logic                 done_reg;

    logic [1:0]           op_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [GEN_W-1:0]     gen_in_reg;
    logic [WB-1:0]        word_reg;
    logic                 found_reg;
    logic [SW-1:0]        slot_reg;
    logic [WORD_BITS-1:0] occ_rd_reg;
    logic [GEN_BITS-1:0]  gen_rd_reg;
    logic                 alloc_ok_reg;

    logic [1:0]           status_reg;
    logic [IDX_W-1:0]     gidx_reg;
    logic [GEN_W-1:0]     ggen_reg;
    logic                 alive_reg;

    logic [31:0]          limit;
    logic [SW-1:0]        cap_slot;
    logic                 sum_found;
    logic [WB-1:0]        sum_word;
    logic                 free_found;
    logic [5:0]           free_off;
    logic [SW-1:0]        alloc_slot;
    logic [SW-1:0]        gen_raddr;
    logic [WORD_BITS-1:0] bit_mask;
    logic                 occ_bit;
    logic                 in_range;
    logic                 gen_match;
    logic [GEN_BITS-1:0]  gen_inc;

    logic [1:0]           res_status;
    logic [IDX_W-1:0]     res_idx;
    logic [GEN_W-1:0]     res_gen;
    logic                 res_alive;
    logic                 occ_we;
    logic [WORD_BITS-1:0] occ_wdata;
    logic                 gen_we;
    logic                 sum_we;
    logic                 sum_val;

    // active limit saturates at the built capacity
    assign limit = (32'(slots_in_use_reg) > 32'(SLOTS)) ? 32'(SLOTS)
                                                         : 32'(slots_in_use_reg);
    assign cap_slot   = SW'(slot_index);
    assign alloc_slot = {word_reg, free_off};
    assign gen_raddr  = cmd.find ? alloc_slot : slot_reg;
    assign bit_mask   = TOP_BIT >> slot_reg[5:0];
    assign occ_bit    = |(occ_rd_reg & bit_mask);
    assign in_range   = 32'(idx_reg) < limit;
    assign gen_match  = 32'(gen_rd_reg) == gen_in_reg;
    assign gen_inc    = gen_rd_reg + GEN_BITS'(1);

    assign stat.clear_done = (clr_cnt_reg == LAST_SLOT);
    assign stat.is_alloc   = (op_reg == OP_ALLOC);

    // lowest word that still has a free slot
    always_comb
    begin
        sum_found = 1'b0;
        sum_word  = '0;
        for (int i = WORDS - 1; i >= 0; i--)
        begin
            if (summary_reg[i])
            begin
                sum_found = 1'b1;
                sum_word  = WB'(i);
            end
        end
    end

    // lowest free slot within the word, slot offset 0 sits at the msb
    always_comb
    begin
        free_found = 1'b0;
        free_off   = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--)
        begin
            if (!occ_rd_reg[WORD_BITS - 1 - k])
            begin
                free_found = 1'b1;
                free_off   = 6'(k);
            end
        end
    end

    always_comb
    begin
        res_status = ST_STALE;
        res_idx    = idx_reg;
        res_gen    = '0;
        res_alive  = 1'b0;
        occ_we     = 1'b0;
        occ_wdata  = occ_rd_reg;
        gen_we     = 1'b0;
        sum_we     = 1'b0;
        sum_val    = 1'b0;
        priority if (op_reg == OP_ALLOC)
        begin
            if (alloc_ok_reg)
            begin
                res_status = ST_OK;
                res_idx    = IDX_W'(slot_reg);
                res_gen    = GEN_W'(gen_rd_reg);
                occ_we     = 1'b1;
                occ_wdata  = occ_rd_reg | bit_mask;
                sum_we     = 1'b1;
                sum_val    = ~&(occ_rd_reg | bit_mask);
            end
            else
            begin
                res_status = ST_FULL;
                res_idx    = '0;
            end
        end
        else if (op_reg == OP_UNUSED)
        begin
            res_status = ST_STALE;
        end
        else if (!in_range)
        begin
            res_status = ST_RANGE;
        end
        else if (op_reg == OP_DELETE)
        begin
            res_gen = GEN_W'(gen_rd_reg);
            if (gen_match)
            begin
                // clears the bit whether or not it was set
                res_status = ST_OK;
                res_gen    = GEN_W'(gen_inc);
                occ_we     = 1'b1;
                occ_wdata  = occ_rd_reg & ~bit_mask;
                gen_we     = 1'b1;
                sum_we     = 1'b1;
                sum_val    = 1'b1;
            end
        end
        else
        begin
            res_gen = GEN_W'(gen_rd_reg);
            if (occ_bit && gen_match)
            begin
                res_status = ST_OK;
                res_alive  = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= SLOTS_RESET;
            clr_cnt_reg      <= '0;
            summary_reg      <= '1;
            done_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                slots_in_use_reg <= cfg_wr_data;
            end
            if (cmd.clear && !stat.clear_done)
            begin
                clr_cnt_reg <= clr_cnt_reg + SW'(1);
            end
            if (cmd.exec && sum_we)
            begin
                summary_reg[word_reg] <= sum_val;
            end
            done_reg <= cmd.exec;
        end
    end

    // request and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= opcode;
            idx_reg    <= slot_index;
            gen_in_reg <= generation;
            slot_reg   <= cap_slot;
            word_reg   <= (opcode == OP_ALLOC) ? sum_word : cap_slot[SW-1:6];
            found_reg  <= sum_found;
        end
        if (cmd.find)
        begin
            slot_reg     <= alloc_slot;
            alloc_ok_reg <= found_reg && free_found && (32'(alloc_slot) < limit);
        end
        if (cmd.exec)
        begin
            status_reg <= res_status;
            gidx_reg   <= res_idx;
            ggen_reg   <= res_gen;
            alive_reg  <= res_alive;
        end
    end

    // memories: one write port and one registered read port each
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            gen_mem[clr_cnt_reg]         <= '0;
            occ_mem[clr_cnt_reg[SW-1:6]] <= '0;
        end
        else
        begin
            if (cmd.exec && gen_we)
            begin
                gen_mem[slot_reg] <= gen_inc;
            end
            if (cmd.exec && occ_we)
            begin
                occ_mem[word_reg] <= occ_wdata;
            end
        end
        if (cmd.read)
        begin
            occ_rd_reg <= occ_mem[word_reg];
        end
        if (cmd.read || cmd.find)
        begin
            gen_rd_reg <= gen_mem[gen_raddr];
        end
    end

    assign done               = done_reg;
    assign status             = status_reg;
    assign granted_index      = gidx_reg;
    assign granted_generation = ggen_reg;
    assign alive              = alive_reg;

endmodule

`default_nettype wire
